// File: src/grcs_pkg.sv
// Package with constants, tables and beat layouts for the gear range code sequencer.
package grcs_pkg;

  parameter int POSITION_COUNT = 11;
  localparam logic [3:0] POS_MAX = 4'(POSITION_COUNT - 1);

  localparam logic [1:0] REG_STEP_DELAY    = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE      = 2'd1;
  localparam logic [1:0] REG_BRAKE_MODE    = 2'd2;
  localparam logic [1:0] REG_INVERT_MASK   = 2'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PINS = 1'b1;

  localparam logic [15:0] STEP_DELAY_RST = 16'd48;
  localparam logic [15:0] DEBOUNCE_RST   = 16'd48;

  localparam logic [3:0] MASK_PLAIN = 4'hE;
  localparam logic [3:0] MASK_BRAKE = 4'hF;

  typedef struct packed {
    logic [3:0] latched_switches;
    logic       shifting;
    logic [3:0] target;
    logic [3:0] position;
    logic [3:0] drive_code;
  } result_t;

  function automatic logic [3:0] range_code(input logic [3:0] pos);
    logic [3:0] c;
    unique case (pos)
      4'd0:    c = 4'd14;
      4'd1:    c = 4'd6;
      4'd2:    c = 4'd4;
      4'd3:    c = 4'd5;
      4'd4:    c = 4'd13;
      4'd5:    c = 4'd5;
      4'd6:    c = 4'd1;
      4'd7:    c = 4'd3;
      4'd8:    c = 4'd2;
      4'd9:    c = 4'd3;
      4'd10:   c = 4'd7;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] map_plain(input logic [3:0] s);
    logic [3:0] t;
    unique case (s)
      4'd2, 4'd3, 4'd6, 4'd7:         t = 4'd4;
      4'd8, 4'd9, 4'd12, 4'd13:       t = 4'd2;
      4'd10, 4'd11:                   t = 4'd10;
      4'd14, 4'd15:                   t = 4'd6;
      default:                        t = 4'd0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] map_brake(input logic [3:0] s);
    logic [3:0] t;
    unique case (s)
      4'd2, 4'd3, 4'd6, 4'd7: t = 4'd4;
      4'd8, 4'd12:            t = 4'd1;
      4'd9, 4'd13:            t = 4'd2;
      4'd10:                  t = 4'd3;
      4'd11:                  t = 4'd10;
      4'd15:                  t = 4'd6;
      default:                t = 4'd0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] lookup_target(input logic brake, input logic [3:0] s);
    logic [3:0] t;
    t = brake ? map_brake(s) : map_plain(s);
    if (t > POS_MAX) t = POS_MAX;
    return t;
  endfunction

endpackage

// File: src/gear_range_code_sequencer.sv
// Top level: debounce, latch, target lookup and range code stepping.
// A result beat is registered in the output or skid register when its input is accepted.
// Throughput: one input beat per cycle while s_tready is high; the state update and
// lookup sit between the state registers and a two-entry output buffer (output register
// plus skid register). s_tready falls only while the skid register holds a beat.
// Reset (rst, synchronous, active high): registers go to defaults, position and target
// park, an initial shift armed, pins assumed 0, output buffer empty.
module gear_range_code_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] pins, [7:4] zero
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] drive_code, [7:4] position, [11:8] target,
                                 // [12] shifting, [16:13] latched_switches, [23:17] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] step_delay;
  logic [15:0] debounce_ticks;
  logic        brake_mode;
  logic [3:0]  invert_mask;

  logic [3:0]  last_pins, last_pins_next;
  logic [15:0] deb_left, deb_left_next;
  logic [3:0]  latched, latched_next;
  logic [3:0]  tgt_idx, tgt_idx_next;
  logic [3:0]  cur_idx, cur_idx_next;
  logic [15:0] step_wait, step_wait_next;
  logic        in_prog, in_prog_next;
  logic        start_pend, start_pend_next;
  logic [3:0]  drv_code, drv_code_next;

  logic        acc, pop, skid_valid;
  logic [3:0]  pins, mask;
  logic        latch_now;
  grcs_pkg::result_t res, out_q, skid_q;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign acc       = s_tvalid && s_tready;
  assign pop       = m_tvalid && m_tready;
  assign pins      = s_tdata[3:0];
  assign mask      = brake_mode ? grcs_pkg::MASK_BRAKE : grcs_pkg::MASK_PLAIN;
  assign m_tdata   = {7'd0, out_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay     <= grcs_pkg::STEP_DELAY_RST;
      debounce_ticks <= grcs_pkg::DEBOUNCE_RST;
      brake_mode     <= 1'b0;
      invert_mask    <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        grcs_pkg::REG_STEP_DELAY:  step_delay     <= cfg_data;
        grcs_pkg::REG_DEBOUNCE:    debounce_ticks <= cfg_data;
        grcs_pkg::REG_BRAKE_MODE:  brake_mode     <= cfg_data[0];
        grcs_pkg::REG_INVERT_MASK: invert_mask    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    last_pins_next  = last_pins;
    deb_left_next   = deb_left;
    latched_next    = latched;
    tgt_idx_next    = tgt_idx;
    cur_idx_next    = cur_idx;
    step_wait_next  = step_wait;
    in_prog_next    = in_prog;
    start_pend_next = start_pend;
    drv_code_next   = drv_code;
    latch_now       = 1'b0;
    if (s_tuser == grcs_pkg::OP_PINS) begin
      if (((pins ^ last_pins) & mask) != 4'd0) deb_left_next = debounce_ticks;
      last_pins_next = pins;
    end else begin
      if (deb_left != 16'd0) begin
        deb_left_next = deb_left - 16'd1;
        if (deb_left == 16'd1) begin
          latched_next = last_pins & mask;
          latch_now    = 1'b1;
        end
      end
      if (in_prog) begin
        if (step_wait != 16'd0) begin
          step_wait_next = step_wait - 16'd1;
        end else begin
          step_wait_next = step_delay;
          if (cur_idx == tgt_idx) begin
            in_prog_next = 1'b0;
          end else begin
            cur_idx_next  = (cur_idx > tgt_idx) ? cur_idx - 4'd1 : cur_idx + 4'd1;
            drv_code_next = grcs_pkg::range_code(cur_idx_next) ^ invert_mask;
          end
        end
      end else if (start_pend) begin
        start_pend_next = 1'b0;
        in_prog_next    = 1'b1;
        step_wait_next  = 16'd0;
      end
      if (latch_now) begin
        tgt_idx_next    = grcs_pkg::lookup_target(brake_mode, latched_next);
        start_pend_next = 1'b1;
      end
    end
    res.drive_code       = drv_code_next;
    res.position         = cur_idx_next;
    res.target           = tgt_idx_next;
    res.shifting         = in_prog_next;
    res.latched_switches = latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pins  <= 4'd0;
      deb_left   <= 16'd0;
      latched    <= 4'd0;
      tgt_idx    <= 4'd0;
      cur_idx    <= 4'd0;
      step_wait  <= 16'd0;
      in_prog    <= 1'b0;
      start_pend <= 1'b1;
      drv_code   <= 4'd0;
    end else if (acc) begin
      last_pins  <= last_pins_next;
      deb_left   <= deb_left_next;
      latched    <= latched_next;
      tgt_idx    <= tgt_idx_next;
      cur_idx    <= cur_idx_next;
      step_wait  <= step_wait_next;
      in_prog    <= in_prog_next;
      start_pend <= start_pend_next;
      drv_code   <= drv_code_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (acc) begin
      if (m_tvalid && !pop) begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end else begin
        out_q    <= res;
        m_tvalid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    cur_idx <= grcs_pkg::POS_MAX)
    else $error("position beyond last position");

  a_tgt_range: assert property (@(posedge clk) disable iff (rst)
    tgt_idx <= grcs_pkg::POS_MAX)
    else $error("target beyond last position");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid beat held with empty output register");

  a_idle_holds_pos: assert property (@(posedge clk) disable iff (rst)
    (acc && !in_prog) |=> cur_idx == $past(cur_idx))
    else $error("position moved while not shifting");
`endif

endmodule

// File: dv/gear_range_code_sequencer_tb.sv
// Self-checking testbench for the gear range code sequencer: directed and random beats vs. predictor.
module gear_range_code_sequencer_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1300;
  // nibble i holds the value for index i
  localparam logic [63:0] POS_CODE    = 64'h0000_0732_315D_546E;
  localparam logic [63:0] PLAIN_TABLE = 64'h6622_AA22_4400_4400;
  localparam logic [63:0] BRAKE_TABLE = 64'h6021_A321_4400_4400;

  class range_seq_scoreboard;
    logic [15:0] step_delay;
    logic [15:0] debounce_ticks;
    logic        brake_mode;
    logic [3:0]  invert_mask;
    logic [3:0]  last_pins;
    logic [15:0] debounce_left;
    logic [3:0]  latched;
    logic [3:0]  target_pos;
    logic [3:0]  current_pos;
    logic [15:0] step_wait;
    logic        shifting;
    logic        start_armed;
    logic [3:0]  drive_code;
    grcs_pkg::result_t expected_q[$];
    int          errors;
    int          n_inputs;
    int          n_results;
    int          n_latches;
    int          n_steps;
    int          n_writes;

    function new();
      step_delay     = grcs_pkg::STEP_DELAY_RST;
      debounce_ticks = grcs_pkg::DEBOUNCE_RST;
      brake_mode     = 1'b0;
      invert_mask    = 4'd0;
      last_pins      = 4'd0;
      debounce_left  = 16'd0;
      latched        = 4'd0;
      target_pos     = 4'd0;
      current_pos    = 4'd0;
      step_wait      = 16'd0;
      shifting       = 1'b0;
      start_armed    = 1'b1;
      drive_code     = 4'd0;
      errors         = 0;
      n_inputs       = 0;
      n_results      = 0;
      n_latches      = 0;
      n_steps        = 0;
      n_writes       = 0;
    endfunction

    function logic [3:0] switch_mask();
      return brake_mode ? grcs_pkg::MASK_BRAKE : grcs_pkg::MASK_PLAIN;
    endfunction

    function logic [3:0] target_of(input logic [3:0] sw);
      logic [3:0] t;
      t = brake_mode ? BRAKE_TABLE[4*sw +: 4] : PLAIN_TABLE[4*sw +: 4];
      if (t > grcs_pkg::POS_MAX) t = grcs_pkg::POS_MAX;
      return t;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [15:0] value);
      n_writes++;
      case (idx)
        grcs_pkg::REG_STEP_DELAY:  step_delay = value;
        grcs_pkg::REG_DEBOUNCE:    debounce_ticks = value;
        grcs_pkg::REG_BRAKE_MODE:  brake_mode = value[0];
        grcs_pkg::REG_INVERT_MASK: invert_mask = value[3:0];
        default: ;
      endcase
    endfunction

    function void advance_tick();
      logic latch_now;
      latch_now = 1'b0;
      if (debounce_left != 0) begin
        debounce_left = debounce_left - 16'd1;
        if (debounce_left == 0) begin
          latched = last_pins & switch_mask();
          latch_now = 1'b1;
          n_latches++;
        end
      end
      if (shifting) begin
        if (step_wait != 0) begin
          step_wait = step_wait - 16'd1;
        end else begin
          step_wait = step_delay;
          if (current_pos == target_pos) begin
            shifting = 1'b0;
          end else begin
            if (current_pos > target_pos) current_pos = current_pos - 4'd1;
            else current_pos = current_pos + 4'd1;
            drive_code = POS_CODE[4*current_pos +: 4] ^ invert_mask;
            n_steps++;
          end
        end
      end else if (start_armed) begin
        start_armed = 1'b0;
        shifting = 1'b1;
        step_wait = 16'd0;
      end
      if (latch_now) begin
        target_pos = target_of(latched);
        start_armed = 1'b1;
      end
    endfunction

    function void note_input(input logic op, input logic [3:0] pins);
      grcs_pkg::result_t r;
      n_inputs++;
      if (op == grcs_pkg::OP_PINS) begin
        if (((pins ^ last_pins) & switch_mask()) != 4'd0) debounce_left = debounce_ticks;
        last_pins = pins;
      end else begin
        advance_tick();
      end
      r.drive_code       = drive_code;
      r.position         = current_pos;
      r.target           = target_pos;
      r.shifting         = shifting;
      r.latched_switches = latched;
      expected_q.push_back(r);
    endfunction

    function void compare(input string field, input logic [6:0] exp_v, input logic [6:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_result(input logic [23:0] beat);
      grcs_pkg::result_t got;
      grcs_pkg::result_t want;
      n_results++;
      got = beat[16:0];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, beat);
        return;
      end
      want = expected_q.pop_front();
      compare("drive_code", 7'(want.drive_code), 7'(got.drive_code));
      compare("position", 7'(want.position), 7'(got.position));
      compare("target", 7'(want.target), 7'(got.target));
      compare("shifting", 7'(want.shifting), 7'(got.shifting));
      compare("latched_switches", 7'(want.latched_switches), 7'(got.latched_switches));
      compare("padding", 7'd0, beat[23:17]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit settled();
      return !shifting && !start_armed && debounce_left == 0;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [3:0] pins, [7:4] zero
  logic        s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [3:0] drive_code, [7:4] position, [11:8] target,
                          // [12] shifting, [16:13] latched_switches, [23:17] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  range_seq_scoreboard sb;
  bit no_idle;
  int phases;

  gear_range_code_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_item(input logic op, input logic [3:0] pins);
    int gap;
    bit ok;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, pins};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_input(op, pins);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(grcs_pkg::OP_TICK, 4'($urandom_range(0, 15)));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    sb.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] step, input logic [15:0] deb,
                           input logic mode, input logic [3:0] inv);
    drain();
    write_reg(grcs_pkg::REG_STEP_DELAY, step);
    write_reg(grcs_pkg::REG_DEBOUNCE, deb);
    write_reg(grcs_pkg::REG_BRAKE_MODE, {15'd0, mode});
    write_reg(grcs_pkg::REG_INVERT_MASK, {12'd0, inv});
    phases++;
  endtask

  // force a latch under the current settings, then run until the shift is over
  task automatic settle();
    send_item(grcs_pkg::OP_PINS, sb.last_pins ^ 4'h8);
    while (!sb.settled()) send_item(grcs_pkg::OP_TICK, 4'($urandom_range(0, 15)));
  endtask

  task automatic random_phase(input int n_items);
    int first;
    int k;
    first = sb.n_inputs;
    while (sb.n_inputs - first < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(grcs_pkg::OP_PINS, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 3) == 0) send_item(grcs_pkg::OP_PINS, 4'($urandom_range(0, 15)));
        k = int'(sb.debounce_ticks) + (int'(sb.step_delay) + 1) * $urandom_range(1, 11) + 2;
        send_ticks(k);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin : sink
    int stall;
    bit ok;
    logic [23:0] beat;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        ok = m_tvalid;
        beat = m_tdata;
        @(posedge clk);
      end while (!ok);
      sb.check_result(beat);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [3:0] sw;
    sb = new();
    no_idle = 1'b0;
    phases = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'd0;
    s_tuser   <= grcs_pkg::OP_TICK;
    m_tready  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= grcs_pkg::REG_STEP_DELAY;
    cfg_data  <= 16'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: armed initial shift, then a long debounce left running
    send_ticks(2);
    send_item(grcs_pkg::OP_PINS, 4'h6);
    send_item(grcs_pkg::OP_TICK, 4'hF);

    configure(16'd0, 16'd1, 1'b0, 4'h0);
    send_item(grcs_pkg::OP_PINS, 4'h0);
    send_ticks(3);
    send_item(grcs_pkg::OP_PINS, 4'h1);          // park brake bit only, masked out
    send_ticks(2);
    send_item(grcs_pkg::OP_PINS, 4'hA);          // low gear
    send_ticks(5);
    send_item(grcs_pkg::OP_PINS, 4'hF);          // retarget mid shift
    send_ticks(4);

    configure(16'd1, 16'd2, 1'b1, 4'hF);
    send_item(grcs_pkg::OP_PINS, 4'h8);
    send_ticks(8);

    // zero debounce: change is never latched
    configure(16'd0, 16'd0, 1'b0, 4'h5);
    send_item(grcs_pkg::OP_PINS, 4'h4);
    send_ticks(3);

    // extreme step delay and debounce
    configure(16'd0, 16'd2, 1'b0, 4'h0);
    settle();
    sw = sb.latched;
    drain();
    write_reg(grcs_pkg::REG_STEP_DELAY, 16'hFFFF);
    write_reg(grcs_pkg::REG_DEBOUNCE, 16'd3);
    send_item(grcs_pkg::OP_PINS, sw ^ 4'h8);
    send_item(grcs_pkg::OP_PINS, sw);
    send_ticks(6);
    drain();
    write_reg(grcs_pkg::REG_DEBOUNCE, 16'hFFFF);
    send_item(grcs_pkg::OP_PINS, sw ^ 4'h8);
    send_ticks(4);
    send_item(grcs_pkg::OP_PINS, sw ^ 4'h9);
    send_ticks(6);
    configure(16'd1, 16'd3, 1'b0, 4'h0);
    send_item(grcs_pkg::OP_PINS, sw);

    while (sb.n_inputs < ITEM_TARGET) begin
      no_idle = (phases % 4 == 1);
      configure(16'($urandom_range(0, 3)),
                ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4)),
                1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      random_phase(150);
    end
    drain();

    $display("Run covered %0d input beats, %0d result beats, %0d register writes, %0d phases;",
             sb.n_inputs, sb.n_results, sb.n_writes, phases);
    $display("%0d debounced latches and %0d position steps were predicted.",
             sb.n_latches, sb.n_steps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
